[rtl/rpv_pkg.sv]
// Shared widths, codes and item type for the radial velocity block.
package rpv_pkg;

   localparam int POINT_W    = 20;
   localparam int VEL_W      = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam int PROD_W  = POINT_W + VEL_W;        // x*vx
   localparam int SQ_W    = 2 * POINT_W - 1;        // x*x, unsigned
   localparam int R_W     = SQ_W + 1;               // x*x + y*y
   localparam int NUM_W   = PROD_W + 1;             // x*vx + y*vy
   localparam int N_W     = PROD_W;                 // |num|
   localparam int HALF_W  = N_W / 2;
   localparam int PART_W  = 2 * HALF_W;
   localparam int Q_W     = 16;                     // search width
   localparam int ACC_W   = 78;                     // search accumulators, signed

   localparam int FIFO_DEPTH_DEF = 4;

   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY_X  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY_Y  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_MOTION_VALID = CSR_IDX_W'(2);

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_ARG_ERR = 1'b1;

   // item handed from front to back
   typedef struct packed {
      logic [PART_W-1:0]       part_hh;
      logic [PART_W-1:0]       part_hl;
      logic [PART_W-1:0]       part_ll;
      logic [R_W-1:0]          range_sq;
      logic                    neg;
      logic                    bypass;
      logic signed [VEL_W-1:0] bypass_val;
      logic                    status;
      logic                    last;
   } work_type;

endpackage

[rtl/rpv_if.sv]
// Channel interfaces: point requests, velocity responses, register writes.
interface rpv_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rpv_pkg::POINT_W-1:0]     point_x;
   logic signed [rpv_pkg::POINT_W-1:0]     point_y;
   logic                                   last_point;
   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface rpv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rpv_pkg::VEL_W-1:0]       radial_velocity;
   logic                                   status;
   logic                                   last_out;
   modport source (output valid, radial_velocity, status, last_out, input ready);
   modport sink   (input valid, radial_velocity, status, last_out, output ready);
endinterface

interface rpv_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [rpv_pkg::CSR_IDX_W-1:0]          index;
   logic [rpv_pkg::CSR_DATA_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rpv_front.sv]
// Front end: registers, products and classification of each point.
module rpv_front (
   input  logic                clock,
   input  logic                reset,
   rpv_req_if.sink             req,
   rpv_csr_if.sink             csr,
   output logic                push,
   output rpv_pkg::work_type   push_data,
   input  logic                fifo_ready
);

   logic signed [rpv_pkg::VEL_W-1:0] vx_ff, vy_ff;
   logic                             mv_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vx_ff <= '0;
         vy_ff <= '0;
         mv_ff <= 1'b0;
      end else if (csr.valid) begin
         unique case (csr.index)
            rpv_pkg::REG_VELOCITY_X:   vx_ff <= csr.data[rpv_pkg::VEL_W-1:0];
            rpv_pkg::REG_VELOCITY_Y:   vy_ff <= csr.data[rpv_pkg::VEL_W-1:0];
            rpv_pkg::REG_MOTION_VALID: mv_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   logic en;
   logic f1_v_ff, f2_v_ff, f3_v_ff;

   // stage 1: products
   logic signed [rpv_pkg::PROD_W-1:0] pxvx_ff, pyvy_ff;
   logic [rpv_pkg::SQ_W-1:0]          xx_ff, yy_ff;
   logic                              st1_ff, org1_ff, last1_ff;
   logic signed [rpv_pkg::VEL_W-1:0]  vx1_ff;
   logic signed [2*rpv_pkg::POINT_W-1:0] xx_full, yy_full;

   // stage 2: sums
   logic [rpv_pkg::R_W-1:0]           r2_ff;
   logic [rpv_pkg::N_W-1:0]           n2_ff;
   logic                              neg2_ff, byp2_ff, st2_ff, last2_ff;
   logic signed [rpv_pkg::VEL_W-1:0]  bval2_ff;
   logic signed [rpv_pkg::NUM_W-1:0]  num;
   logic [rpv_pkg::NUM_W-1:0]         num_abs;

   // stage 3: square of |num| in halves
   rpv_pkg::work_type                 f3_ff;
   logic [rpv_pkg::HALF_W-1:0]        nh, nl;

   assign en        = !f3_v_ff || fifo_ready;
   assign req.ready = en;
   assign push      = f3_v_ff && fifo_ready;
   assign push_data = f3_ff;

   assign xx_full = req.point_x * req.point_x;
   assign yy_full = req.point_y * req.point_y;
   assign num     = rpv_pkg::NUM_W'(pxvx_ff) + rpv_pkg::NUM_W'(pyvy_ff);
   assign num_abs = num[rpv_pkg::NUM_W-1] ? rpv_pkg::NUM_W'(-num) : num;
   assign nh      = n2_ff[rpv_pkg::N_W-1:rpv_pkg::HALF_W];
   assign nl      = n2_ff[rpv_pkg::HALF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= req.valid;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pxvx_ff  <= req.point_x * vx_ff;
         pyvy_ff  <= req.point_y * vy_ff;
         xx_ff    <= xx_full[rpv_pkg::SQ_W-1:0];
         yy_ff    <= yy_full[rpv_pkg::SQ_W-1:0];
         st1_ff   <= !mv_ff;
         org1_ff  <= (req.point_x == '0) && (req.point_y == '0);
         vx1_ff   <= vx_ff;
         last1_ff <= req.last_point;

         r2_ff    <= rpv_pkg::R_W'(xx_ff) + rpv_pkg::R_W'(yy_ff);
         n2_ff    <= num_abs[rpv_pkg::N_W-1:0];
         neg2_ff  <= num[rpv_pkg::NUM_W-1];
         byp2_ff  <= st1_ff || org1_ff;
         bval2_ff <= st1_ff ? '0 : vx1_ff;
         st2_ff   <= st1_ff;
         last2_ff <= last1_ff;

         f3_ff.part_hh    <= nh * nh;
         f3_ff.part_hl    <= nh * nl;
         f3_ff.part_ll    <= nl * nl;
         f3_ff.range_sq   <= r2_ff;
         f3_ff.neg        <= neg2_ff;
         f3_ff.bypass     <= byp2_ff;
         f3_ff.bypass_val <= bval2_ff;
         f3_ff.status     <= st2_ff ? rpv_pkg::STATUS_ARG_ERR : rpv_pkg::STATUS_OK;
         f3_ff.last       <= last2_ff;
      end
   end

endmodule

[rtl/rpv_fifo.sv]
// Short queue between front and back.
module rpv_fifo #(
   parameter int DEPTH = rpv_pkg::FIFO_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rpv_pkg::work_type   push_data,
   output logic                not_full,
   input  logic                pop,
   output rpv_pkg::work_type   pop_data,
   output logic                not_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rpv_pkg::work_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [CW-1:0] cnt_ff;

   assign not_full  = cnt_ff != CW'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign pop_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         if (pop)  rp_ff <= (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
         cnt_ff <= cnt_ff + CW'(push) - CW'(pop);
      end
   end

endmodule

[rtl/rpv_back.sv]
// Back end: bit-per-stage quotient search, rounding and saturation.
module rpv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                fifo_valid,
   input  rpv_pkg::work_type   fifo_data,
   output logic                pop,
   rpv_rsp_if.source           rsp
);

   localparam int NS = rpv_pkg::Q_W;
   localparam int AW = rpv_pkg::ACC_W;

   typedef struct packed {
      logic signed [AW-1:0]             acc_a;  // (2q-1)^2 * r
      logic signed [AW-1:0]             acc_b;  // (2q-1) * r
      logic signed [AW-1:0]             lim4;   // 4 n^2
      logic signed [AW-1:0]             r;
      logic [rpv_pkg::Q_W-1:0]          q;
      logic                             neg;
      logic                             bypass;
      logic signed [rpv_pkg::VEL_W-1:0] bypass_val;
      logic                             status;
      logic                             last;
   } stage_type;

   logic      en;
   logic      v_ff [NS+1];
   stage_type s_ff [NS+1];
   stage_type s0_in;
   logic      out_v_ff;

   assign en  = !out_v_ff || rsp.ready;
   assign pop = en && fifo_valid;

   always_comb begin
      s0_in.r      = AW'(fifo_data.range_sq);
      s0_in.acc_a  = s0_in.r;
      s0_in.acc_b  = -s0_in.r;
      s0_in.lim4   = (AW'(fifo_data.part_hh) << (2 * rpv_pkg::HALF_W + 2))
                   + (AW'(fifo_data.part_hl) << (rpv_pkg::HALF_W + 3))
                   + (AW'(fifo_data.part_ll) << 2);
      s0_in.q          = '0;
      s0_in.neg        = fifo_data.neg;
      s0_in.bypass     = fifo_data.bypass;
      s0_in.bypass_val = fifo_data.bypass_val;
      s0_in.status     = fifo_data.status;
      s0_in.last       = fifo_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset)   v_ff[0] <= 1'b0;
      else if (en) v_ff[0] <= fifo_valid;
   end

   always_ff @(posedge clock) begin
      if (en) s_ff[0] <= s0_in;
   end

   for (genvar j = 0; j < NS; j++) begin : g_step
      localparam int K = NS - 1 - j;
      logic signed [AW-1:0] trial;
      logic                 take;
      stage_type            step_in;

      assign trial = s_ff[j].acc_a + (s_ff[j].acc_b <<< (K + 2)) + (s_ff[j].r <<< (2 * K + 2));
      assign take  = trial <= s_ff[j].lim4;

      always_comb begin
         step_in = s_ff[j];
         if (take) begin
            step_in.acc_a = trial;
            step_in.acc_b = s_ff[j].acc_b + (s_ff[j].r <<< (K + 1));
            step_in.q[K]  = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset)   v_ff[j+1] <= 1'b0;
         else if (en) v_ff[j+1] <= v_ff[j];
      end

      always_ff @(posedge clock) begin
         if (en) s_ff[j+1] <= step_in;
      end
   end

   // clamp to the signed range and apply the sign
   stage_type                        fin;
   logic [rpv_pkg::Q_W:0]            lim, qc, qs;
   logic signed [rpv_pkg::VEL_W-1:0] vel_in;
   logic signed [rpv_pkg::VEL_W-1:0] vel_ff;
   logic                             st_ff, last_ff;

   assign fin    = s_ff[NS];
   assign lim    = fin.neg ? (rpv_pkg::Q_W+1)'(32768) : (rpv_pkg::Q_W+1)'(32767);
   assign qc     = ({1'b0, fin.q} > lim) ? lim : {1'b0, fin.q};
   assign qs     = fin.neg ? -qc : qc;
   assign vel_in = fin.bypass ? fin.bypass_val : qs[rpv_pkg::VEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset)   out_v_ff <= 1'b0;
      else if (en) out_v_ff <= v_ff[NS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vel_ff  <= vel_in;
         st_ff   <= fin.status;
         last_ff <= fin.last;
      end
   end

   assign rsp.valid           = out_v_ff;
   assign rsp.radial_velocity = vel_ff;
   assign rsp.status          = st_ff;
   assign rsp.last_out        = last_ff;

endmodule

[rtl/radar_point_radial_velocity.sv]
// Top level of the radar point radial velocity block.
//
// req: one radar point per item (point_x, point_y in 1/1024 m, last_point).
// rsp: one item per point, in order: radial_velocity (1/256 m/s, rounded to
//      nearest, saturated), status (argument error when motion is not valid,
//      velocity then zero) and last_out copied from the point.
// csr: register writes (velocity_x, velocity_y, motion_valid); always ready.
//      Write only while no point is in flight.
// Throughput: one point per cycle sustained while rsp is ready.
// Pipeline: 3 front stages (products, sums, square of the numerator), the
//   queue, one set-up stage, 16 search stages (one quotient bit each,
//   shift-add only) and the output register.
// The front stalls only when the queue is full; the back freezes while a
//   response waits, so the queue absorbs the front's items in flight.
// Reset (synchronous) clears the registers to zero, the queue and all valids.
module radar_point_radial_velocity #(
   parameter int FIFO_DEPTH = rpv_pkg::FIFO_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rpv_req_if.sink    req,
   rpv_rsp_if.source  rsp,
   rpv_csr_if.sink    csr
);

   logic              push, pop, not_full, not_empty;
   rpv_pkg::work_type push_data, pop_data;

   // front: config and per-point products
   rpv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .push       (push),
      .push_data  (push_data),
      .fifo_ready (not_full)
   );

   // decoupling queue
   rpv_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .not_full  (not_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   // back: quotient search and output register
   rpv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (not_empty),
      .fifo_data  (pop_data),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

[rtl/rpv_checker.sv]
// Port-level checks for the radial velocity block, bound to the top level.
module rpv_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [rpv_pkg::VEL_W-1:0]   rsp_vel,
   input logic                               rsp_status,
   input logic                               rsp_last,
   input logic                               csr_valid,
   input logic                               csr_ready
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vel)
      && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_vel == '0)
      else $error("argument error with non-zero velocity");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind radar_point_radial_velocity rpv_checker u_rpv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_vel    (rsp.radial_velocity),
   .rsp_status (rsp.status),
   .rsp_last   (rsp.last_out),
   .csr_valid  (csr.valid),
   .csr_ready  (csr.ready)
);
